/* src/hbridge_motor_drive_and_odometry_defines.svh */
// Assertion macros for the H-bridge drive and odometry block.
// Included by the port checker; needs nothing else.
`ifndef HBRIDGE_MOTOR_DRIVE_AND_ODOMETRY_DEFINES_SVH
`define HBRIDGE_MOTOR_DRIVE_AND_ODOMETRY_DEFINES_SVH

// same-cycle implication, off during reset
`define HBMD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbmd same-cycle check failed");

// next-cycle implication, off during reset
`define HBMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbmd next-cycle check failed");

`endif

/* src/hbmd_pkg.sv */
// Types, codes and helper functions for the H-bridge drive and odometry block.
// Used by every module of the block; depends on nothing.
package hbmd_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int MOTOR_W    = $clog2(NUM_MOTORS);
  localparam int CFG_W      = 15;
  localparam int IDX_W      = 1;

  localparam int STALE_FRAMES_DEF    = 25;
  localparam int WATCHDOG_RELOAD_DEF = 4;

  localparam logic [CFG_W-1:0] PWM_PERIOD_RESET = 15'd2400;
  localparam logic [CFG_W-1:0] THRESHOLD_RESET  = 15'd240;

  localparam logic [IDX_W-1:0] REG_PWM_PERIOD       = 1'd0;
  localparam logic [IDX_W-1:0] REG_DRIVEN_THRESHOLD = 1'd1;

  localparam logic [MOTOR_W-1:0] MTR_LEFT  = 2'd0;
  localparam logic [MOTOR_W-1:0] MTR_RIGHT = 2'd1;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_FWD  = 2'd1;
  localparam logic [1:0] TGT_REV  = 2'd2;
  localparam logic [1:0] TGT_BOTH = 2'd3;

  localparam logic [1:0] HS_KEEP  = 2'd0;
  localparam logic [1:0] HS_SET   = 2'd1;
  localparam logic [1:0] HS_CLEAR = 2'd2;

  localparam logic [1:0] PIN_KEEP  = 2'd0;
  localparam logic [1:0] PIN_PLAIN = 2'd1;
  localparam logic [1:0] PIN_PWM   = 2'd2;

  typedef enum logic [1:0] {
    REQ_CMD   = 2'd0,
    REQ_FRAME = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_HYST  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    DIR_UNINIT = 4'b0001,
    DIR_FWD    = 4'b0010,
    DIR_BACK   = 4'b0100,
    DIR_IDLE   = 4'b1000
  } dir_t;

  typedef logic signed [15:0] power_t;

  typedef struct packed {
    req_t                       req_type;
    logic [MOTOR_W-1:0]         motor_index;
    logic                       frame_start;
    logic signed [31:0]         enc_delta;
    logic [31:0]                enc_time;
    power_t [NUM_MOTORS-1:0]    cmd_power;
  } item_t;

  typedef struct packed {
    logic [1:0]  compare_target;
    logic [14:0] compare_value;
    logic [1:0]  high_side_action;
    logic [1:0]  fwd_low_mode;
    logic [1:0]  rev_low_mode;
    logic [2:0]  driven_flags;
  } drive_res_t;

  typedef struct packed {
    logic signed [31:0] delta;
    logic [31:0]        position;
    logic [31:0]        interval;
    logic               encoder_updated;
    logic               stale;
  } odom_res_t;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor;
    odom_res_t          odom;
    drive_res_t         drive;
  } res_t;

  function automatic logic [15:0] abs16(input power_t v);
    abs16 = v[15] ? (~v + 16'd1) : v;
  endfunction

  function automatic power_t scale_power(input power_t cmd, input logic [CFG_W-1:0] period);
    logic [15:0] mag;
    logic [30:0] prod;
    logic [15:0] m;
    mag  = abs16(cmd);
    prod = 31'(mag) * 31'(period);
    m    = prod[30:15];
    scale_power = cmd[15] ? power_t'(~m + 16'd1) : power_t'(m);
  endfunction

endpackage

/* src/hbmd_drive.sv */
// Power commands, link watchdog, scaled power, direction machines and driven flags.
// Depends on hbmd_pkg.
module hbmd_drive #(
  parameter int WATCHDOG_RELOAD = hbmd_pkg::WATCHDOG_RELOAD_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  hbmd_pkg::item_t           item,
  input  logic [hbmd_pkg::CFG_W-1:0] pwm_period,
  input  logic [hbmd_pkg::CFG_W-1:0] driven_threshold,
  output hbmd_pkg::drive_res_t      res,
  output logic                      tread_fwd
);
  import hbmd_pkg::*;

  power_t [NUM_MOTORS-1:0] commanded;
  power_t [NUM_MOTORS-1:0] commanded_next;
  power_t [NUM_MOTORS-1:0] cmd_eff;
  power_t [NUM_MOTORS-1:0] scaled;
  power_t [NUM_MOTORS-1:0] scaled_next;
  dir_t   [NUM_MOTORS-1:0] drive_dir;
  dir_t   [NUM_MOTORS-1:0] drive_dir_next;
  dir_t   [NUM_MOTORS-1:0] last_dir;
  dir_t   [NUM_MOTORS-1:0] last_dir_next;
  logic   [2:0]            watchdog;
  logic   [2:0]            watchdog_next;

  power_t      p;
  logic [15:0] pmag;
  dir_t        pdir;
  logic [15:0] thr;

  assign tread_fwd = (last_dir[item.motor_index] == DIR_FWD);
  assign thr       = {1'b0, driven_threshold};

  always_comb begin
    commanded_next = commanded;
    cmd_eff        = commanded;
    scaled_next    = scaled;
    drive_dir_next = drive_dir;
    last_dir_next  = last_dir;
    watchdog_next  = watchdog;
    res            = '0;
    p    = scaled[item.motor_index];
    pmag = abs16(p);
    if (p > 0) begin
      pdir = DIR_FWD;
    end else if (p < 0) begin
      pdir = DIR_BACK;
    end else begin
      pdir = DIR_IDLE;
    end

    unique case (item.req_type)
      REQ_CMD: begin
        commanded_next = item.cmd_power;
        watchdog_next  = 3'(WATCHDOG_RELOAD);
      end
      REQ_FRAME: begin
        if (item.frame_start) begin
          if (watchdog == 3'd0) begin
            cmd_eff = '0;
          end else begin
            watchdog_next = watchdog - 3'd1;
          end
        end
        commanded_next = cmd_eff;
        scaled_next[item.motor_index] = scale_power(cmd_eff[item.motor_index], pwm_period);
      end
      REQ_TICK: begin
        if (drive_dir[item.motor_index] == pdir) begin
          if (pdir == DIR_FWD) begin
            res.compare_target = TGT_FWD;
          end else begin
            res.compare_target = TGT_REV;
          end
          res.compare_value = pmag[14:0];
        end else if (drive_dir[item.motor_index] != DIR_IDLE) begin
          res.compare_target = TGT_BOTH;
          res.fwd_low_mode   = PIN_PLAIN;
          res.rev_low_mode   = PIN_PLAIN;
          drive_dir_next[item.motor_index] = DIR_IDLE;
        end else begin
          if (pdir == DIR_FWD) begin
            res.high_side_action = HS_SET;
            res.fwd_low_mode     = PIN_PWM;
          end else begin
            res.high_side_action = HS_CLEAR;
            res.rev_low_mode     = PIN_PWM;
          end
          drive_dir_next[item.motor_index] = pdir;
          last_dir_next[item.motor_index]  = pdir;
        end
      end
      REQ_HYST: begin
        last_dir_next[MTR_LEFT]  = DIR_BACK;
        last_dir_next[MTR_RIGHT] = DIR_BACK;
      end
    endcase

    res.driven_flags[0] = abs16(scaled_next[2]) > thr;
    res.driven_flags[1] = abs16(scaled_next[3]) > thr;
    res.driven_flags[2] = (abs16(scaled_next[0]) > thr) || (abs16(scaled_next[1]) > thr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      commanded <= '0;
      scaled    <= '0;
      for (int k = 0; k < NUM_MOTORS; k++) begin
        drive_dir[k] <= DIR_UNINIT;
        last_dir[k]  <= DIR_UNINIT;
      end
      watchdog  <= '0;
    end else if (en) begin
      commanded <= commanded_next;
      scaled    <= scaled_next;
      drive_dir <= drive_dir_next;
      last_dir  <= last_dir_next;
      watchdog  <= watchdog_next;
    end
  end

endmodule

/* src/hbmd_odom.sv */
// Encoder odometry: position, edge interval and per-motor staleness counters.
// Depends on hbmd_pkg.
module hbmd_odom #(
  parameter int STALE_FRAMES = hbmd_pkg::STALE_FRAMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  hbmd_pkg::item_t      item,
  input  logic                 tread_fwd,
  output hbmd_pkg::odom_res_t  res
);
  import hbmd_pkg::*;

  logic [NUM_MOTORS-1:0][31:0] position;
  logic [NUM_MOTORS-1:0][31:0] position_next;
  logic [NUM_MOTORS-1:0][31:0] edge_time;
  logic [NUM_MOTORS-1:0][31:0] edge_time_next;
  logic [NUM_MOTORS-1:0][7:0]  frames;
  logic [NUM_MOTORS-1:0][7:0]  frames_next;

  logic [7:0]         cnt;
  logic signed [31:0] sdelta;

  always_comb begin
    position_next  = position;
    edge_time_next = edge_time;
    frames_next    = frames;
    res            = '0;
    cnt            = frames[item.motor_index];
    sdelta         = item.enc_delta;
    if (item.req_type == REQ_FRAME) begin
      if (cnt != 8'hFF) begin
        cnt = cnt + 8'd1;
      end
      frames_next[item.motor_index] = cnt;
      if (item.enc_delta != 32'sd0) begin
        if (item.motor_index <= MTR_RIGHT && !tread_fwd) begin
          sdelta = -item.enc_delta;
        end
        position_next[item.motor_index]  = position[item.motor_index] + $unsigned(sdelta);
        res.interval                     = edge_time[item.motor_index] - item.enc_time;
        edge_time_next[item.motor_index] = item.enc_time;
        frames_next[item.motor_index]    = '0;
        res.delta                        = sdelta;
        res.encoder_updated              = 1'b1;
      end else begin
        res.stale = cnt > 8'(STALE_FRAMES);
      end
    end
    res.position = position_next[item.motor_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      edge_time <= '0;
      frames    <= '0;
    end else if (en) begin
      position  <= position_next;
      edge_time <= edge_time_next;
      frames    <= frames_next;
    end
  end

endmodule

/* src/hbridge_motor_drive_and_odometry.sv */
// Top level: request register, config registers, drive and odometry units, result register.
// Depends on hbmd_pkg, hbmd_drive and hbmd_odom.
//
//   channel   signals                     direction   accepted when
//   request   req_valid / req_stall       in          req_valid && !req_stall
//   result    res_valid / res_stall       out         res_valid && !res_stall
//   config    wr_en / wr_index / wr_data  in          wr_en
//
// Every request yields one result; one request per cycle while req_stall is low.
// The request register feeds one combinational pass into the result register.
// req_stall rises only when both registers hold and res_stall is high.
// Reset (rst, synchronous) clears all motor state and loads the register defaults.
module hbridge_motor_drive_and_odometry #(
  parameter int STALE_FRAMES    = hbmd_pkg::STALE_FRAMES_DEF,
  parameter int WATCHDOG_RELOAD = hbmd_pkg::WATCHDOG_RELOAD_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [hbmd_pkg::IDX_W-1:0]  wr_index,
  input  logic [hbmd_pkg::CFG_W-1:0]  wr_data,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  req_type,
  input  logic [1:0]                  motor_index,
  input  logic                        frame_start,
  input  logic signed [31:0]          enc_delta,
  input  logic [31:0]                 enc_time,
  input  logic signed [15:0]          cmd_power_0,
  input  logic signed [15:0]          cmd_power_1,
  input  logic signed [15:0]          cmd_power_2,
  input  logic signed [15:0]          cmd_power_3,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [1:0]                  motor_out,
  output logic signed [31:0]          delta_out,
  output logic [31:0]                 position_out,
  output logic [31:0]                 interval_out,
  output logic                        encoder_updated,
  output logic                        stale,
  output logic [1:0]                  compare_target,
  output logic [14:0]                 compare_value,
  output logic [1:0]                  high_side_action,
  output logic [1:0]                  fwd_low_mode,
  output logic [1:0]                  rev_low_mode,
  output logic [2:0]                  driven_flags
);
  import hbmd_pkg::*;

  logic [CFG_W-1:0] pwm_period;
  logic [CFG_W-1:0] driven_threshold;

  item_t      item;
  item_t      item_in;
  logic       item_full;
  logic       accept;
  logic       fire;
  res_t       res;
  drive_res_t drive_res;
  odom_res_t  odom_res;
  logic       tread_fwd;

  assign req_stall = item_full && res_valid && res_stall;
  assign accept    = req_valid && !req_stall;
  assign fire      = item_full && !(res_valid && res_stall);

  always_comb begin
    item_in.req_type     = req_t'(req_type);
    item_in.motor_index  = motor_index;
    item_in.frame_start  = frame_start;
    item_in.enc_delta    = enc_delta;
    item_in.enc_time     = enc_time;
    item_in.cmd_power[0] = cmd_power_0;
    item_in.cmd_power[1] = cmd_power_1;
    item_in.cmd_power[2] = cmd_power_2;
    item_in.cmd_power[3] = cmd_power_3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period       <= PWM_PERIOD_RESET;
      driven_threshold <= THRESHOLD_RESET;
    end else if (wr_en) begin
      if (wr_index == REG_PWM_PERIOD) begin
        pwm_period <= wr_data;
      end
      if (wr_index == REG_DRIVEN_THRESHOLD) begin
        driven_threshold <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (accept) begin
      item_full <= 1'b1;
    end else if (fire) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
  end

  hbmd_drive #(
    .WATCHDOG_RELOAD(WATCHDOG_RELOAD)
  ) u_drive (
    .clk              (clk),
    .rst              (rst),
    .en               (fire),
    .item             (item),
    .pwm_period       (pwm_period),
    .driven_threshold (driven_threshold),
    .res              (drive_res),
    .tread_fwd        (tread_fwd)
  );

  hbmd_odom #(
    .STALE_FRAMES(STALE_FRAMES)
  ) u_odom (
    .clk       (clk),
    .rst       (rst),
    .en        (fire),
    .item      (item),
    .tread_fwd (tread_fwd),
    .res       (odom_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.motor <= item.motor_index;
      res.odom  <= odom_res;
      res.drive <= drive_res;
    end
  end

  assign motor_out        = res.motor;
  assign delta_out        = res.odom.delta;
  assign position_out     = res.odom.position;
  assign interval_out     = res.odom.interval;
  assign encoder_updated  = res.odom.encoder_updated;
  assign stale            = res.odom.stale;
  assign compare_target   = res.drive.compare_target;
  assign compare_value    = res.drive.compare_value;
  assign high_side_action = res.drive.high_side_action;
  assign fwd_low_mode     = res.drive.fwd_low_mode;
  assign rev_low_mode     = res.drive.rev_low_mode;
  assign driven_flags     = res.drive.driven_flags;

endmodule

/* src/hbmd_checker.sv */
// Port-level checks for the H-bridge drive and odometry block, bound to the top level.
// Depends on hbmd_pkg and hbridge_motor_drive_and_odometry_defines.svh.
`include "hbridge_motor_drive_and_odometry_defines.svh"

module hbmd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        res_valid,
  input logic                        res_stall,
  input logic signed [31:0]          delta_out,
  input logic [31:0]                 interval_out,
  input logic                        encoder_updated,
  input logic                        stale,
  input logic [1:0]                  compare_target,
  input logic [14:0]                 compare_value,
  input logic [1:0]                  high_side_action,
  input logic [1:0]                  fwd_low_mode,
  input logic [1:0]                  rev_low_mode
);
  import hbmd_pkg::*;

  logic upd_ok;
  logic no_upd_ok;
  logic both_off;

  assign upd_ok    = delta_out != 32'sd0 && !stale;
  assign no_upd_ok = delta_out == 32'sd0 && interval_out == 32'd0;
  assign both_off  = compare_value == 15'd0 && fwd_low_mode == PIN_PLAIN &&
                     rev_low_mode == PIN_PLAIN && high_side_action == HS_KEEP;

  `HBMD_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid)
  `HBMD_ASSERT_IMPLY(a_upd_delta, clk, rst, res_valid && encoder_updated, upd_ok)
  `HBMD_ASSERT_IMPLY(a_no_upd_zero, clk, rst, res_valid && !encoder_updated, no_upd_ok)
  `HBMD_ASSERT_IMPLY(a_both_zeroed, clk, rst, res_valid && compare_target == TGT_BOTH, both_off)

endmodule

bind hbridge_motor_drive_and_odometry hbmd_checker u_hbmd_checker (.*);
